// File: hdl/cqfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqfb_pkg
// Shared types and constants of the circular message queue: operation and
// status codes, register indexes, reset values and the result record.
// ----------------------------------------------------------------------------
package cqfb_pkg;

  // Widths fixed by the item and register layout
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int DATA_W     = 32;

  // Operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_SEND_BACK  = 2'd0,
    OP_SEND_FRONT = 2'd1,
    OP_RECEIVE    = 2'd2,
    OP_RESTART    = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CARRIES_DATA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0] QUEUE_LENGTH_RESET  = 5'd16;
  localparam logic             CARRIES_DATA_RESET  = 1'b1;
  localparam logic [CNT_W-1:0] INITIAL_COUNT_RESET = 5'd0;

  // Result record passed from the queue control to the result register
  typedef struct packed {
    status_t          status;
    logic             is_read;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] spaces;
  } res_t;

endpackage

// File: hdl/cqfb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqfb_ram
// Generic single-port RAM with registered read data; the read register holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module cqfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on we, capture read data on re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hdl/cqfb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqfb_ctrl
// Queue control: configuration registers, indices and item count. Decodes
// one operation per cycle, issues the slot access and forms the result record.
// ----------------------------------------------------------------------------
module cqfb_ctrl
  import cqfb_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int WORD_W = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Accepted operation
  input  logic                  accept,
  input  op_t                   op,
  input  logic [WORD_W-1:0]     word,
  // Slot memory access
  output logic                  ram_we,
  output logic                  ram_re,
  output logic [AW-1:0]         ram_addr,
  output logic [WORD_W-1:0]     ram_wdata,
  // Result of the current operation
  output res_t                  res
);

  // Indices stay below the largest effective length, min(DEPTH, 31); after
  // the length shrinks they may sit above the current one until they wrap
  localparam int PTR_W = (AW < CNT_W) ? AW : CNT_W;
  localparam int CAP   = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CNT_W-1:0] CAP_L = CNT_W'(CAP);
  localparam logic [CNT_W-1:0] LEN_RESET =
    (QUEUE_LENGTH_RESET > CAP_L) ? CAP_L : QUEUE_LENGTH_RESET;

  logic [CNT_W-1:0] queue_length;
  logic             carries_data;
  logic [CNT_W-1:0] initial_count;

  logic [PTR_W-1:0] write_index, write_index_next;
  logic [PTR_W-1:0] read_index, read_index_next;
  logic [CNT_W-1:0] item_count, item_count_next;
  logic [CNT_W-1:0] len;
  logic [PTR_W-1:0] slot;

  // Advance an index, wrap at the effective length
  function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] idx,
                                                input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] n;
    n = CNT_W'(idx) + CNT_W'(1);
    return (n >= lim) ? '0 : PTR_W'(n);
  endfunction

  // Move an index back, wrap to the last slot in use
  function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] idx,
                                                  input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] last;
    last = lim - CNT_W'(1);
    return (idx == '0) ? PTR_W'(last) : idx - PTR_W'(1);
  endfunction

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_length  <= QUEUE_LENGTH_RESET;
      carries_data  <= CARRIES_DATA_RESET;
      initial_count <= INITIAL_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUEUE_LENGTH:  queue_length  <= cfg_data;
        CFG_CARRIES_DATA:  carries_data  <= cfg_data[0];
        CFG_INITIAL_COUNT: initial_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective length: zero acts as one, clamp to min(DEPTH, 31)
  always_comb begin
    if (queue_length == '0) begin
      len = CNT_W'(1);
    end else if (queue_length > CAP_L) begin
      len = CAP_L;
    end else begin
      len = queue_length;
    end
  end

  // Decode the operation
  always_comb begin
    write_index_next = write_index;
    read_index_next  = read_index;
    item_count_next  = item_count;
    slot             = write_index;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    res.status       = ST_DONE;
    res.is_read      = 1'b0;
    unique case (op) inside
      OP_SEND_BACK, OP_SEND_FRONT: begin
        if (item_count >= len) begin
          res.status = ST_FULL;
        end else begin
          if (carries_data) begin
            ram_we = accept;
            if (op == OP_SEND_BACK) begin
              slot             = write_index;
              write_index_next = step_up(write_index, len);
            end else begin
              slot            = read_index;
              read_index_next = step_down(read_index, len);
            end
          end
          item_count_next = item_count + CNT_W'(1);
        end
      end
      OP_RECEIVE: begin
        if (item_count == '0) begin
          res.status = ST_EMPTY;
        end else begin
          if (carries_data) begin
            read_index_next = step_up(read_index, len);
            slot            = read_index_next;
            ram_re          = accept;
            res.is_read     = 1'b1;
          end
          item_count_next = item_count - CNT_W'(1);
        end
      end
      OP_RESTART: begin
        write_index_next = '0;
        read_index_next  = step_down('0, len);
        item_count_next  = (initial_count < len) ? initial_count : len;
      end
      default: ;
    endcase
    res.count  = item_count_next;
    res.spaces = (item_count_next < len) ? len - item_count_next : '0;
  end

  assign ram_addr  = AW'(slot);
  assign ram_wdata = word;

  // Commit indices and count on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= PTR_W'(LEN_RESET - CNT_W'(1));
      item_count  <= '0;
    end else if (accept) begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      item_count  <= item_count_next;
    end
  end

endmodule

// File: hdl/circular_queue_front_back_send_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_front_back_send_core
// Bounded circular message queue with send to back, send to front, receive
// and restart, answering each operation with one status item.
// ----------------------------------------------------------------------------
// The queue takes one operation per clock while the input is not stalled and
// returns its result in the cycle after acceptance. That delay comes from the
// registered read port of the slot memory: indices and count are decided in
// the cycle an item is accepted, the slot is read or written at that edge, and
// the read word arrives together with the registered status, count and free
// space. A waiting result stalls the input only while the downstream side is
// not ready. The slot memory is not cleared: after a restart with a nonzero
// initial count a receive can read unwritten slots. Configuration writes are
// always taken and should only be issued while no operation is in flight.
module circular_queue_front_back_send_core
  import cqfb_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // Operation stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // [31:0] item_data
  input  logic [1:0]            s_tuser,   // [1:0] op
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata,   // [31:0] data_out, [36:32] count,
                                           // [41:37] spaces, [47:42] zero
  output logic [1:0]            m_tuser,   // [1:0] status
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WORD_W = (ITEM_WIDTH < DATA_W) ? ITEM_WIDTH : DATA_W;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              accept;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  res_t              res_cur;
  res_t              res;
  logic              res_valid;
  logic [DATA_W-1:0] data_out;

  assign cfg_ready = 1'b1;
  assign s_tready  = !res_valid || m_tready;
  assign accept    = s_tvalid && s_tready;

  cqfb_ctrl #(
    .DEPTH  (DEPTH),
    .WORD_W (WORD_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .op        (op_t'(s_tuser)),
    .word      (s_tdata[WORD_W-1:0]),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .res       (res_cur)
  );

  cqfb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Hold the result until taken, load a new one on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_cur;
    end
  end

  // The read register holds its word while the result waits
  assign data_out = res.is_read ? DATA_W'(ram_rdata) : '0;

  assign m_tvalid = res_valid;
  assign m_tuser  = res.status;
  assign m_tdata  = {6'd0, res.spaces, res.count, data_out};

  // Every accepted item yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted item produced no result");

  // A full answer leaves no free slot
  a_full_no_space: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_FULL |-> res.spaces == '0)
    else $error("full status with free space");

  // An empty answer reports no items and reads no word
  a_empty_no_read: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_EMPTY |-> res.count == '0 && !res.is_read)
    else $error("empty status with items or read data");

  // A word is read only by a successful receive
  a_read_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_read |-> res.status == ST_DONE)
    else $error("read data on a failed operation");

endmodule
